@@ rtl/core/ujesc_pkg.sv @@
// ujesc_pkg: shared types and character constants for the UTF-8 JSON escaper.
// No dependencies; imported by every module of the block.
package ujesc_pkg;

    localparam int RUN_MAX = 8;
    localparam int IDX_W   = $clog2(RUN_MAX);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_RS     = 8'd30;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_U   = 8'h75;

    localparam logic [7:0] LEAD4_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_MASK = 8'hC0;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
        logic       string_end;
        logic       truncated;
    } out_word_t;

    // one decoded run of output characters
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] chars;
        logic [IDX_W-1:0]        last_idx;
        logic                    str_end;
        logic                    trunc;
    } run_t;

    function automatic logic [7:0] hex_lower(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10)
        begin
            r = CH_ZERO + {4'd0, nib};
        end
        else
        begin
            r = CH_LO_A + {4'd0, nib} - 8'd10;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/ujesc_decode.sv @@
// ujesc_decode: sequence state and single-pass decode of one input word into a run.
// Depends on ujesc_pkg.
module ujesc_decode
    import ujesc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  logic     esc_all,
    input  in_word_t word,
    output logic     run_load,
    output run_t     run
);

    logic [20:0] acc_reg, acc_next;
    logic [1:0]  pend_reg, pend_next;

    logic [20:0] acc_c;
    logic [1:0]  pend_c;
    logic [23:0] cp24;
    logic [23:0] cp_sh;
    logic [7:0]  b;

    always_comb
    begin
        b        = word.in_byte;
        acc_c    = acc_reg;
        pend_c   = pend_reg;
        run_load = 1'b0;
        run      = '0;
        cp24     = '0;
        cp_sh    = '0;

        if (pend_reg != 2'd0)
        begin
            acc_c  = {acc_reg[14:0], b[5:0]};
            pend_c = pend_reg - 2'd1;
            if (pend_c == 2'd0)
            begin
                cp24 = {3'd0, acc_c};
                run_load = 1'b1;
                run.chars[0] = CH_BSLASH;
                run.chars[1] = CH_LO_U;
                if (acc_c[20])
                begin
                    cp_sh = cp24;
                    run.last_idx = IDX_W'(7);
                end
                else if (acc_c[19:16] != 4'd0)
                begin
                    cp_sh = cp24 << 4;
                    run.last_idx = IDX_W'(6);
                end
                else
                begin
                    cp_sh = cp24 << 8;
                    run.last_idx = IDX_W'(5);
                end
                for (int i = 0; i < 6; i++)
                begin
                    run.chars[2+i] = hex_lower(cp_sh[23-4*i -: 4]);
                end
                acc_c = '0;
            end
        end
        else if ((b & LEAD4_MASK) == LEAD4_MASK)
        begin
            acc_c  = {18'd0, b[2:0]};
            pend_c = 2'd3;
        end
        else if ((b & LEAD3_MASK) == LEAD3_MASK)
        begin
            acc_c  = {17'd0, b[3:0]};
            pend_c = 2'd2;
        end
        else if ((b & LEAD2_MASK) == LEAD2_MASK)
        begin
            acc_c  = {16'd0, b[4:0]};
            pend_c = 2'd1;
        end
        else
        begin
            run_load     = 1'b1;
            run.chars[0] = b;
            run.last_idx = '0;
            if (esc_all)
            begin
                case (b)
                    CH_QUOTE, CH_BSLASH:
                    begin
                        run.chars[0] = CH_BSLASH;
                        run.chars[1] = b;
                        run.last_idx = IDX_W'(1);
                    end
                    CH_BS:
                    begin
                        run.chars[0] = CH_BSLASH;
                        run.chars[1] = CH_LO_B;
                        run.last_idx = IDX_W'(1);
                    end
                    CH_FF:
                    begin
                        run.chars[0] = CH_BSLASH;
                        run.chars[1] = CH_LO_F;
                        run.last_idx = IDX_W'(1);
                    end
                    CH_TAB:
                    begin
                        run.chars[0] = CH_BSLASH;
                        run.chars[1] = CH_LO_T;
                        run.last_idx = IDX_W'(1);
                    end
                    CH_LF:
                    begin
                        run.chars[0] = CH_BSLASH;
                        run.chars[1] = CH_LO_N;
                        run.last_idx = IDX_W'(1);
                    end
                    CH_CR:
                    begin
                        run.chars[0] = CH_BSLASH;
                        run.chars[1] = CH_LO_R;
                        run.last_idx = IDX_W'(1);
                    end
                    CH_RS:
                    begin
                        run.chars[0] = CH_BSLASH;
                        run.chars[1] = CH_LO_U;
                        run.chars[2] = CH_ZERO;
                        run.chars[3] = CH_ZERO;
                        run.chars[4] = CH_ONE;
                        run.chars[5] = CH_UP_E;
                        run.last_idx = IDX_W'(5);
                    end
                    default:
                    begin
                        run.chars[0] = b;
                    end
                endcase
            end
        end

        run.str_end = word.last_byte;

        // string ends with a sequence still open
        if (word.last_byte && (pend_c != 2'd0))
        begin
            run_load     = 1'b1;
            run          = '0;
            run.chars[0] = CH_NUL;
            run.str_end  = 1'b1;
            run.trunc    = 1'b1;
        end

        if (word.last_byte)
        begin
            acc_next  = '0;
            pend_next = '0;
        end
        else
        begin
            acc_next  = acc_c;
            pend_next = pend_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            pend_reg <= '0;
        end
        else if (accept)
        begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
        end
    end

endmodule

@@ rtl/core/ujesc_serial.sv @@
// ujesc_serial: run buffer that hands out one character word per cycle while char_stall is low.
// Depends on ujesc_pkg.
module ujesc_serial
    import ujesc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      run_load,
    input  run_t      run,
    output logic      busy,
    output logic      char_valid,
    input  logic      char_stall,
    output out_word_t char_word
);

    logic                      valid_reg, valid_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [RUN_MAX-1:0][7:0]   chars_reg;
    logic [IDX_W-1:0]          last_reg;
    logic                      end_reg;
    logic                      trunc_reg;
    logic                      take;
    logic                      done;

    assign take = valid_reg && !char_stall;
    assign done = take && (idx_reg == last_reg);
    assign busy = valid_reg && !done;

    assign char_valid           = valid_reg;
    assign char_word.out_char   = chars_reg[idx_reg];
    assign char_word.run_last   = (idx_reg == last_reg);
    assign char_word.string_end = (idx_reg == last_reg) && end_reg;
    assign char_word.truncated  = trunc_reg;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (run_load)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (done)
        begin
            valid_next = 1'b0;
        end
        else if (take)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_load)
        begin
            chars_reg <= run.chars;
            last_reg  <= run.last_idx;
            end_reg   <= run.str_end;
            trunc_reg <= run.trunc;
        end
    end

endmodule

@@ rtl/core/utf8_json_escape_top.sv @@
// Output: a result word appears in the cycle after its last input word is taken.
// Throughput: one input word per cycle for single-character results while char_stall
// is low; a run of n characters (n up to 8) holds the input stalled until its last
// character is taken from the one-character-per-cycle output buffer.
// Reset: rst_n asynchronous; clears sequence state, output buffer and escape-all flag.
module utf8_json_escape_top
    import ujesc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  in_word_t  byte_word,
    output logic      char_valid,
    input  logic      char_stall,
    output out_word_t char_word,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);

    logic esc_all_reg;
    logic busy;
    logic accept;
    logic run_load;
    run_t run;

    assign byte_stall = busy;
    assign accept     = byte_valid && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_all_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            esc_all_reg <= cfg_wdata;
        end
    end

    ujesc_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .esc_all  (esc_all_reg),
        .word     (byte_word),
        .run_load (run_load),
        .run      (run)
    );

    ujesc_serial u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .run_load   (run_load && accept),
        .run        (run),
        .busy       (busy),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word)
    );

endmodule

@@ rtl/core/ujesc_chk.sv @@
// ujesc_chk: port-level checks on the escaper, bound to the top level.
// Depends on ujesc_pkg and utf8_json_escape_top.
module ujesc_chk
    import ujesc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      byte_valid,
    input logic      byte_stall,
    input logic      char_valid,
    input logic      char_stall,
    input out_word_t char_word
);

    a_trunc_word: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_word.truncated |->
            char_word.run_last && char_word.string_end && (char_word.out_char == CH_NUL))
        else $error("truncation word malformed");

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_word.string_end |-> char_word.run_last)
        else $error("string end not on run end");

    a_take_only_at_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_stall && char_valid |-> !char_stall && char_word.run_last)
        else $error("input taken while run pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid && $stable(char_word))
        else $error("stalled output word changed");

endmodule

bind utf8_json_escape_top ujesc_chk u_chk (.*);
